FILE: hw/rtl/window_link_validity_fsm_defines.svh
// Assertion macros shared by the RTL.
`ifndef WINDOW_LINK_VALIDITY_FSM_DEFINES_SVH
`define WINDOW_LINK_VALIDITY_FSM_DEFINES_SVH

// Combinational property, checked on every rising clock edge out of reset.
`define WLV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define WLV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/wlv_pkg.sv
package wlv_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 64;

  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned VERD_W    = 2;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned TOT_W     = 7;

  // message status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_REPEATED = 3'd1;
  localparam logic [ST_W-1:0] ST_WRONGSEQ = 3'd2;
  localparam logic [ST_W-1:0] ST_ERROR    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTAVAIL = 3'd4;
  localparam logic [ST_W-1:0] ST_NONEW    = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERR_INIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERR_INVALID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERR_VALID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OK_INIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OK_INVALID  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OK_VALID    = 3'd6;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_INIT  = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    M_DEINIT  = 3'd0,
    M_NODATA  = 3'd1,
    M_INIT    = 3'd2,
    M_VALID   = 3'd3,
    M_INVALID = 3'd4
  } mode_e;

  typedef enum logic [VERD_W-1:0] {
    V_OK         = 2'd0,
    V_NOTOK      = 2'd1,
    V_WRONGSTATE = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [CFG_W-1:0] window_size;
    logic [CFG_W-1:0] max_err_init;
    logic [CFG_W-1:0] max_err_invalid;
    logic [CFG_W-1:0] max_err_valid;
    logic [CFG_W-1:0] min_ok_init;
    logic [CFG_W-1:0] min_ok_invalid;
    logic [CFG_W-1:0] min_ok_valid;
  } cfg_t;

  function automatic logic is_ok(input logic [ST_W-1:0] s);
    return s == ST_OK;
  endfunction

  function automatic logic is_err(input logic [ST_W-1:0] s);
    return (s == ST_REPEATED) || (s == ST_WRONGSEQ) || (s == ST_ERROR);
  endfunction

endpackage

FILE: hw/rtl/wlv_if.sv
interface wlv_in_if import wlv_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            op;
  logic [ST_W-1:0] msg_status;

  modport source (output valid, op, msg_status, input ready);
  modport sink   (input valid, op, msg_status, output ready);
endinterface

interface wlv_out_if import wlv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VERD_W-1:0] verdict;
  logic [MODE_W-1:0] fsm_state;
  logic [TOT_W-1:0]  ok_total;
  logic [TOT_W-1:0]  err_total;

  modport source (output valid, verdict, fsm_state, ok_total, err_total, input ready);
  modport sink   (input valid, verdict, fsm_state, ok_total, err_total, output ready);
endinterface

interface wlv_cfg_if import wlv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/wlv_ring_ram.sv
module wlv_ring_ram import wlv_pkg::*; #(
  parameter int unsigned DEPTH = MAX_WINDOW_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [ST_W-1:0] wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [ST_W-1:0] rdata_o
);

  logic [ST_W-1:0] mem_q [DEPTH];
  logic [ST_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/wlv_cfg_regs.sv
module wlv_cfg_regs import wlv_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  wlv_cfg_if.sink       cfg_i,
  output cfg_t          cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_WINDOW_SIZE:     cfg_d.window_size     = cfg_i.data;
        CFG_MAX_ERR_INIT:    cfg_d.max_err_init    = cfg_i.data;
        CFG_MAX_ERR_INVALID: cfg_d.max_err_invalid = cfg_i.data;
        CFG_MAX_ERR_VALID:   cfg_d.max_err_valid   = cfg_i.data;
        CFG_MIN_OK_INIT:     cfg_d.min_ok_init     = cfg_i.data;
        CFG_MIN_OK_INVALID:  cfg_d.min_ok_invalid  = cfg_i.data;
        CFG_MIN_OK_VALID:    cfg_d.min_ok_valid    = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_size     <= CFG_W'(1);
      cfg_q.max_err_init    <= '0;
      cfg_q.max_err_invalid <= '0;
      cfg_q.max_err_valid   <= '0;
      cfg_q.min_ok_init     <= CFG_W'(1);
      cfg_q.min_ok_invalid  <= CFG_W'(1);
      cfg_q.min_ok_valid    <= CFG_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/window_link_validity_fsm.sv
// Channel   Dir  Payload                                   Transfer
// in_i      in   op, msg_status                            valid & ready
// out_o     out  verdict, fsm_state, ok_total, err_total   valid & ready
// cfg_i     in   index, data                               valid & ready (ready tied high)
//
// One item per cycle sustained while the output accepts; each result goes from its input transfer
// into the update stage (ring read at the transfer) and then into the output register.
// The ring read for the next item uses the pointer just computed; a same-entry hit on the
// write in flight is forwarded. A fill count marks entries written since the last clear.
// Reset: no clearing pass, the block takes items from the first cycle after reset.
// A stalled output holds the update stage; the input stalls only when that stage is full.

`include "window_link_validity_fsm_defines.svh"

module window_link_validity_fsm import wlv_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wlv_in_if.sink     in_i,
  wlv_out_if.source  out_o,
  wlv_cfg_if.sink    cfg_i
);

  localparam int unsigned PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned EW = (CW > CFG_W) ? CW : CFG_W;

  cfg_t cfg;

  wlv_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // state
  mode_e           mode_q, mode_d;
  logic [PW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic [CW-1:0]   ok_q, ok_d;
  logic [CW-1:0]   err_q, err_d;

  // update stage
  logic            s1_valid_q;
  logic            s1_op_q;
  logic [ST_W-1:0] s1_st_q;
  logic            byp_q;
  logic [ST_W-1:0] byp_data_q;
  logic            old_vld_q;

  // output register
  logic              out_valid_q;
  verdict_e          verdict_q, verdict_d;
  mode_e             fsm_state_q;
  logic [TOT_W-1:0]  ok_tot_q, err_tot_q;

  logic            s1_fire, in_fire;
  logic            we;
  logic [ST_W-1:0] ram_rdata;
  logic [ST_W-1:0] old_st;
  logic [EW-1:0]   ws_ext, w_eff;
  logic [CW-1:0]   ok_add, err_add, fill_wr, ptr_inc;
  logic [PW-1:0]   ptr_wr;
  logic [EW-1:0]   ok_ext, err_ext;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  wlv_ring_ram #(
    .DEPTH (MAX_WINDOW),
    .AW    (PW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ptr_q),
    .wdata_i (s1_st_q),
    .re_i    (in_fire),
    .raddr_i (ptr_d),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ws_ext = EW'(cfg.window_size);
    if (ws_ext == '0) begin
      w_eff = EW'(1);
    end else if (ws_ext > EW'(MAX_WINDOW)) begin
      w_eff = EW'(MAX_WINDOW);
    end else begin
      w_eff = ws_ext;
    end
  end

  // ring write: retire the overwritten entry, count the new one
  always_comb begin
    old_st  = byp_q ? byp_data_q : (old_vld_q ? ram_rdata : ST_NOTAVAIL);
    ok_add  = ok_q - CW'(is_ok(old_st) && (ok_q != '0)) + CW'(is_ok(s1_st_q));
    err_add = err_q - CW'(is_err(old_st) && (err_q != '0)) + CW'(is_err(s1_st_q));
    ptr_inc = CW'(ptr_q) + CW'(1);
    fill_wr = (ptr_inc > fill_q) ? ptr_inc : fill_q;
    ptr_wr  = (EW'(ptr_q) >= (w_eff - EW'(1))) ? '0 : ptr_inc[PW-1:0];
    ok_ext  = EW'(ok_add);
    err_ext = EW'(err_add);
  end

  always_comb begin
    mode_d    = mode_q;
    ptr_d     = ptr_q;
    fill_d    = fill_q;
    ok_d      = ok_q;
    err_d     = err_q;
    we        = 1'b0;
    verdict_d = V_NOTOK;
    if (s1_fire) begin
      if (s1_op_q == OP_INIT) begin
        mode_d    = M_DEINIT;
        ptr_d     = '0;
        fill_d    = '0;
        ok_d      = '0;
        err_d     = '0;
        verdict_d = V_OK;
      end else begin
        unique case (mode_q)
          M_DEINIT: begin
            mode_d    = M_NODATA;
            ptr_d     = '0;
            fill_d    = '0;
            ok_d      = '0;
            err_d     = '0;
            verdict_d = V_WRONGSTATE;
          end
          M_NODATA: begin
            if ((s1_st_q != ST_ERROR) && (s1_st_q != ST_NONEW)) begin
              mode_d = M_INIT;
            end
          end
          M_INIT, M_VALID, M_INVALID: begin
            we     = 1'b1;
            ptr_d  = ptr_wr;
            fill_d = fill_wr;
            ok_d   = ok_add;
            err_d  = err_add;
            unique case (mode_q)
              M_INIT: begin
                if (err_ext <= EW'(cfg.max_err_init) && ok_ext >= EW'(cfg.min_ok_init)) begin
                  mode_d    = M_VALID;
                  verdict_d = V_OK;
                end else if (err_ext > EW'(cfg.max_err_init)) begin
                  mode_d = M_INVALID;
                end
              end
              M_VALID: begin
                if (err_ext <= EW'(cfg.max_err_valid) && ok_ext >= EW'(cfg.min_ok_valid)) begin
                  verdict_d = V_OK;
                end else begin
                  mode_d = M_INVALID;
                end
              end
              default: begin
                if (err_ext <= EW'(cfg.max_err_invalid) &&
                    ok_ext >= EW'(cfg.min_ok_invalid)) begin
                  mode_d    = M_VALID;
                  verdict_d = V_OK;
                end
              end
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_DEINIT;
      ptr_q  <= '0;
      fill_q <= '0;
      ok_q   <= '0;
      err_q  <= '0;
    end else begin
      mode_q <= mode_d;
      ptr_q  <= ptr_d;
      fill_q <= fill_d;
      ok_q   <= ok_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= in_i.op;
      s1_st_q    <= in_i.msg_status;
      byp_q      <= we && (ptr_d == ptr_q);
      byp_data_q <= s1_st_q;
      old_vld_q  <= CW'(ptr_d) < fill_d;
    end
    if (s1_fire) begin
      verdict_q   <= verdict_d;
      fsm_state_q <= mode_d;
      ok_tot_q    <= TOT_W'(ok_d);
      err_tot_q   <= TOT_W'(err_d);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.verdict   = verdict_q;
  assign out_o.fsm_state = fsm_state_q;
  assign out_o.ok_total  = ok_tot_q;
  assign out_o.err_total = err_tot_q;

  `WLV_ASSERT(a_cnt_le_fill, (EW'(ok_q) + EW'(err_q)) <= EW'(fill_q), "counts exceed filled entries")
  `WLV_ASSERT(a_ptr_le_fill, CW'(ptr_q) <= fill_q, "ring pointer beyond filled prefix")
  `WLV_ASSERT(a_idle_empty, (mode_q != M_DEINIT && mode_q != M_NODATA) || fill_q == '0, "ring not empty before init state")
  `WLV_ASSERT_NEXT(a_fire_out, s1_fire, out_valid_q, "update without output")

endmodule

FILE: tb/sv/tb_window_link_validity_fsm.sv
`timescale 1ns / 1ps

module tb_window_link_validity_fsm;
  import wlv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 80;

  typedef struct {
    verdict_e         verdict;
    mode_e            fsm_state;
    logic [TOT_W-1:0] ok_total;
    logic [TOT_W-1:0] err_total;
  } link_result_t;

  class link_scoreboard;
    cfg_t            regs;
    mode_e           mode;
    logic [ST_W-1:0] ring [MAX_WINDOW_DEF];
    int unsigned     ptr;
    int unsigned     ok_cnt;
    int unsigned     err_cnt;
    link_result_t    expected_q[$];
    int              fails;

    function new();
      regs.window_size     = 7'd1;
      regs.max_err_init    = 7'd0;
      regs.max_err_invalid = 7'd0;
      regs.max_err_valid   = 7'd0;
      regs.min_ok_init     = 7'd1;
      regs.min_ok_invalid  = 7'd1;
      regs.min_ok_valid    = 7'd1;
      mode  = M_DEINIT;
      fails = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (ring[i]) ring[i] = ST_NOTAVAIL;
      ptr     = 0;
      ok_cnt  = 0;
      err_cnt = 0;
    endfunction

    function bit error_class(logic [ST_W-1:0] s);
      return s == ST_REPEATED || s == ST_WRONGSEQ || s == ST_ERROR;
    endfunction

    function int unsigned span();
      if (regs.window_size == 0) return 1;
      if (regs.window_size > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
      return regs.window_size;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_WINDOW_SIZE:     regs.window_size     = val;
        CFG_MAX_ERR_INIT:    regs.max_err_init    = val;
        CFG_MAX_ERR_INVALID: regs.max_err_invalid = val;
        CFG_MAX_ERR_VALID:   regs.max_err_valid   = val;
        CFG_MIN_OK_INIT:     regs.min_ok_init     = val;
        CFG_MIN_OK_INVALID:  regs.min_ok_invalid  = val;
        CFG_MIN_OK_VALID:    regs.min_ok_valid    = val;
        default: ;
      endcase
    endfunction

    // running counts: retire the overwritten entry, then count the new one
    function void store_status(logic [ST_W-1:0] s);
      int unsigned     w;
      int unsigned     p;
      logic [ST_W-1:0] old;
      w   = span();
      p   = (ptr >= MAX_WINDOW_DEF) ? 0 : ptr;
      old = ring[p];
      if (old == ST_OK && ok_cnt > 0) ok_cnt--;
      if (error_class(old) && err_cnt > 0) err_cnt--;
      ring[p] = s;
      if (s == ST_OK) ok_cnt++;
      if (error_class(s)) err_cnt++;
      ptr = (p >= w - 1) ? 0 : p + 1;
    endfunction

    function void note_input(logic op, logic [ST_W-1:0] s);
      verdict_e     v;
      link_result_t r;
      v = V_NOTOK;
      if (op == OP_INIT) begin
        clear_window();
        mode = M_DEINIT;
        v    = V_OK;
      end else begin
        case (mode)
          M_DEINIT: begin
            mode = M_NODATA;
            clear_window();
            v = V_WRONGSTATE;
          end
          M_NODATA: begin
            if (s != ST_ERROR && s != ST_NONEW) mode = M_INIT;
          end
          M_INIT: begin
            store_status(s);
            if (err_cnt <= regs.max_err_init && ok_cnt >= regs.min_ok_init) begin
              mode = M_VALID;
              v    = V_OK;
            end else if (err_cnt > regs.max_err_init) begin
              mode = M_INVALID;
            end
          end
          M_VALID: begin
            store_status(s);
            if (err_cnt <= regs.max_err_valid && ok_cnt >= regs.min_ok_valid) v = V_OK;
            else mode = M_INVALID;
          end
          default: begin
            store_status(s);
            if (err_cnt <= regs.max_err_invalid && ok_cnt >= regs.min_ok_invalid) begin
              mode = M_VALID;
              v    = V_OK;
            end else begin
              mode = M_INVALID;
            end
          end
        endcase
      end
      r.verdict   = v;
      r.fsm_state = mode;
      r.ok_total  = TOT_W'(ok_cnt);
      r.err_total = TOT_W'(err_cnt);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [VERD_W-1:0] verdict, logic [MODE_W-1:0] fsm_state,
                               logic [TOT_W-1:0] ok_total, logic [TOT_W-1:0] err_total);
      link_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: verdict %0d fsm_state %0d ok_total %0d err_total %0d",
               verdict, fsm_state, ok_total, err_total);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      if (verdict !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, verdict);
        fails++;
      end
      if (fsm_state !== want.fsm_state) begin
        $error("fsm_state: expected %0d, got %0d", want.fsm_state, fsm_state);
        fails++;
      end
      if (ok_total !== want.ok_total) begin
        $error("ok_total: expected %0d, got %0d", want.ok_total, ok_total);
        fails++;
      end
      if (err_total !== want.err_total) begin
        $error("err_total: expected %0d, got %0d", want.err_total, err_total);
        fails++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  wlv_in_if  in_if();
  wlv_out_if out_if();
  wlv_cfg_if cfg_if();

  window_link_validity_fsm dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  link_scoreboard sb;
  bit             calm;
  int unsigned    results_seen;
  int unsigned    cycles;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      results_seen++;
      sb.check_result(out_if.verdict, out_if.fsm_state, out_if.ok_total, out_if.err_total);
    end
  end

  // result side: random stalls plus one long hold-off to back up the input
  initial begin : result_sink
    bit squeezed;
    squeezed = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (!squeezed && results_seen >= 120) begin
        squeezed = 1'b1;
        out_if.ready <= 1'b0;
        repeat (100) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk_i);
    end
  end

  // entered and left at a falling edge; valid stays up for a back-to-back transfer
  task automatic send_item(logic op, logic [ST_W-1:0] s);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.msg_status <= s;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_input(op, s);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic write_all(logic [CFG_W-1:0] ws, logic [CFG_W-1:0] e_init,
                           logic [CFG_W-1:0] e_inv, logic [CFG_W-1:0] e_val,
                           logic [CFG_W-1:0] o_init, logic [CFG_W-1:0] o_inv,
                           logic [CFG_W-1:0] o_val);
    write_reg(CFG_WINDOW_SIZE, ws);
    write_reg(CFG_MAX_ERR_INIT, e_init);
    write_reg(CFG_MAX_ERR_INVALID, e_inv);
    write_reg(CFG_MAX_ERR_VALID, e_val);
    write_reg(CFG_MIN_OK_INIT, o_init);
    write_reg(CFG_MIN_OK_INVALID, o_inv);
    write_reg(CFG_MIN_OK_VALID, o_val);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] pick_limit(int unsigned w);
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'd64;
      2:       return 7'd127;
      default: return CFG_W'($urandom_range(0, w + 1));
    endcase
  endfunction

  function automatic logic [ST_W-1:0] pick_status(int unsigned ok_pct);
    if ($urandom_range(0, 99) < ok_pct) return ST_OK;
    if ($urandom_range(0, 9) < 6) return ST_REPEATED + ST_W'($urandom_range(0, 2));
    return ST_NOTAVAIL + ST_W'($urandom_range(0, 3));
  endfunction

  task automatic run_phase(int unsigned n_items, int unsigned ok_pct);
    int unsigned i;
    send_item(OP_INIT, pick_status(ok_pct));
    for (i = 1; i < n_items; i++) begin
      if ($urandom_range(0, 49) == 0) send_item(OP_INIT, pick_status(ok_pct));
      else send_item(OP_CHECK, pick_status(ok_pct));
    end
    drain();
  endtask

  initial begin : stimulus
    int unsigned      ph;
    int unsigned      w;
    logic [CFG_W-1:0] ws;
    sb               = new();
    calm             = 1'b0;
    results_seen     = 0;
    cycles           = 0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.op         = OP_CHECK;
    in_if.msg_status = ST_OK;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_WINDOW_SIZE;
    cfg_if.data      = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds, window of one
    send_item(OP_CHECK, ST_OK);         // check before init
    send_item(OP_CHECK, ST_ERROR);      // nodata holds on error
    send_item(OP_CHECK, ST_NONEW);      // and on no new data
    send_item(OP_CHECK, 3'd7);          // undefined code leaves nodata
    send_item(OP_CHECK, ST_OK);
    send_item(OP_CHECK, ST_NOTAVAIL);
    send_item(OP_CHECK, ST_OK);
    send_item(OP_CHECK, ST_WRONGSEQ);
    send_item(OP_CHECK, 3'd6);
    send_item(OP_INIT, 3'd7);
    send_item(OP_CHECK, ST_REPEATED);
    send_item(OP_CHECK, ST_REPEATED);
    send_item(OP_CHECK, ST_REPEATED);
    send_item(OP_CHECK, ST_OK);
    send_item(OP_INIT, ST_OK);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        write_all(7'd127, 7'd64, 7'd64, 7'd64, 7'd0, 7'd0, 7'd0);
      end else if (ph == 1) begin
        write_all(7'd0, 7'd0, 7'd0, 7'd0, 7'd64, 7'd64, 7'd64);
      end else if (ph == 2) begin
        write_all(7'd64, 7'd3, 7'd1, 7'd4, 7'd40, 7'd30, 7'd20);
      end else begin
        case ($urandom_range(0, 7))
          0:       ws = 7'd1;
          1:       ws = 7'd64;
          2:       ws = 7'd0;
          3:       ws = 7'd127;
          4:       ws = CFG_W'($urandom_range(2, 4));
          default: ws = CFG_W'($urandom_range(1, 64));
        endcase
        w = (ws == 0) ? 1 : (ws > 64) ? 64 : ws;
        write_all(ws, pick_limit(w / 4), pick_limit(w / 4), pick_limit(w / 3),
                  pick_limit(w), pick_limit(w), pick_limit(w / 2));
      end
      if (ph == PHASES - 1) calm = 1'b1;
      run_phase(PHASE_ITEMS, $urandom_range(30, 95));
    end

    repeat (8) @(negedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
